// File: rtl/ilt_pkg.sv
// ----------------------------------------------------------------------------
// ilt_pkg
// Shared types and constants of the irc line tokenizer: item layouts, token
// kinds, status codes, register indexes and the delimiter bytes.
// ----------------------------------------------------------------------------
package ilt_pkg;

  // line geometry
  localparam int LINE_BYTES = 8192;
  localparam int POS_W      = $clog2(LINE_BYTES + 1);

  // result field widths
  localparam int KIND_W   = 3;
  localparam int INDEX_W  = 6;
  localparam int START_W  = 13;
  localparam int LEN_W    = 14;
  localparam int STATUS_W = 3;
  localparam int LIMIT_W  = 7;

  // configuration port
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_TAG_LIMIT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ARG_LIMIT = CFG_IDX_W'(1);
  localparam logic [LIMIT_W-1:0]   TAG_LIMIT_RESET = LIMIT_W'(32);
  localparam logic [LIMIT_W-1:0]   ARG_LIMIT_RESET = LIMIT_W'(15);

  // entry queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // token kinds
  localparam logic [KIND_W-1:0] KIND_KEY    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_VALUE  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SOURCE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CMD    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ARG    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_STATUS = 3'd5;

  // line status codes
  localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY_TAGS   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_MANY     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY_SOURCE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_CMD       = 3'd4;

  // delimiter bytes
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       end_of_line;
  } byte_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]   token_kind;
    logic [INDEX_W-1:0]  token_index;
    logic [START_W-1:0]  token_start;
    logic [LEN_W-1:0]    token_length;
    logic [STATUS_W-1:0] parse_status;
    logic                last_of_line;
  } token_item_t;

  // what one accepted byte leaves for the back end
  typedef struct packed {
    logic                tok_valid;
    token_item_t         tok;
    logic                sts_valid;
    logic [STATUS_W-1:0] sts_code;
  } entry_t;

endpackage

// File: rtl/ilt_front.sv
// ----------------------------------------------------------------------------
// ilt_front
// Per-byte line parser: tracks the phase of the line and turns each byte into
// at most one token descriptor and, on the final byte, the line status.
// ----------------------------------------------------------------------------
module ilt_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  ilt_pkg::byte_item_t             byte_item,
  input  logic                            cfg_write,
  input  logic [ilt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ilt_pkg::LIMIT_W-1:0]     cfg_data,
  output logic                            entry_push,
  output ilt_pkg::entry_t                 entry
);
  import ilt_pkg::*;

  typedef enum logic [3:0] {
    PH_START, PH_TAGGAP, PH_TAG, PH_GAPSRC, PH_SRC, PH_GAPCMD,
    PH_CMD, PH_GAPARG, PH_ARG, PH_REST, PH_DONE
  } phase_t;

  localparam logic [POS_W-1:0] LINE_END = POS_W'(LINE_BYTES);

  phase_t              phase, phase_next;
  logic [POS_W-1:0]    pos, pos_next;
  logic [POS_W-1:0]    start, start_next;
  logic [LIMIT_W-1:0]  tag_count, tag_count_next;
  logic [LIMIT_W-1:0]  arg_count, arg_count_next;
  logic                value_seen, value_seen_next;
  logic [STATUS_W-1:0] err, err_next;
  logic [LIMIT_W-1:0]  tag_limit, arg_limit;

  logic [7:0]          b;
  logic                in_range;
  logic [POS_W-1:0]    line_end;
  logic [LIMIT_W-1:0]  tidx;
  logic                tok_v;
  logic [KIND_W-1:0]   tok_kind;
  logic [LIMIT_W-1:0]  tok_idx;
  logic [POS_W-1:0]    tok_s, tok_e, tok_len;
  logic                fin_tok;
  logic [KIND_W-1:0]   fin_kind;
  logic [LIMIT_W-1:0]  fin_idx;
  logic [STATUS_W-1:0] fin_st;

  // byte step followed by the end-of-line close
  always_comb begin
    b               = byte_item.line_byte;
    in_range        = pos < LINE_END;
    line_end        = in_range ? pos + POS_W'(1) : pos;
    phase_next      = phase;
    pos_next        = line_end;
    start_next      = start;
    tag_count_next  = tag_count;
    arg_count_next  = arg_count;
    value_seen_next = value_seen;
    err_next        = err;
    tidx            = (tag_count != '0) ? tag_count - LIMIT_W'(1) : '0;
    tok_v           = 1'b0;
    tok_kind        = KIND_KEY;
    tok_idx         = '0;
    tok_s           = start;
    tok_e           = pos;
    fin_tok         = 1'b0;
    fin_kind        = KIND_KEY;
    fin_idx         = '0;
    fin_st          = ST_OK;

    if (in_range) begin
      case (phase)
        PH_START: begin
          if (b == CH_AT) begin
            phase_next = PH_TAGGAP;
          end else if (b == CH_COLON) begin
            start_next = pos + POS_W'(1);
            phase_next = PH_SRC;
          end else if (b == CH_SPACE) begin
            // leading space: empty command
            start_next = pos;
            tok_v      = 1'b1;
            tok_kind   = KIND_CMD;
            tok_s      = pos;
            phase_next = PH_GAPARG;
          end else begin
            start_next = pos;
            phase_next = PH_CMD;
          end
        end
        PH_TAGGAP: begin
          if (b == CH_SPACE) begin
            phase_next = PH_GAPSRC;
          end else if (b != CH_SEMI) begin
            if (tag_count >= tag_limit) begin
              err_next   = ST_TOO_MANY;
              phase_next = PH_DONE;
            end else begin
              tag_count_next  = tag_count + LIMIT_W'(1);
              value_seen_next = 1'b0;
              start_next      = pos;
              phase_next      = PH_TAG;
              // tag opening with '=' has an empty key
              if (b == CH_EQ) begin
                tok_v           = 1'b1;
                tok_kind        = KIND_KEY;
                tok_idx         = tag_count;
                tok_s           = pos;
                value_seen_next = 1'b1;
                start_next      = pos + POS_W'(1);
              end
            end
          end
        end
        PH_TAG: begin
          if (b == CH_SEMI || b == CH_SPACE) begin
            tok_v      = 1'b1;
            tok_kind   = value_seen ? KIND_VALUE : KIND_KEY;
            tok_idx    = tidx;
            phase_next = (b == CH_SEMI) ? PH_TAGGAP : PH_GAPSRC;
          end else if (b == CH_EQ && !value_seen) begin
            tok_v           = 1'b1;
            tok_kind        = KIND_KEY;
            tok_idx         = tidx;
            value_seen_next = 1'b1;
            start_next      = pos + POS_W'(1);
          end
        end
        PH_GAPSRC: begin
          if (b == CH_COLON) begin
            start_next = pos + POS_W'(1);
            phase_next = PH_SRC;
          end else if (b != CH_SPACE) begin
            start_next = pos;
            phase_next = PH_CMD;
          end
        end
        PH_SRC: begin
          if (b == CH_SPACE) begin
            tok_v      = 1'b1;
            tok_kind   = KIND_SOURCE;
            phase_next = PH_GAPCMD;
          end
        end
        PH_GAPCMD: begin
          if (b != CH_SPACE) begin
            start_next = pos;
            phase_next = PH_CMD;
          end
        end
        PH_CMD: begin
          if (b == CH_SPACE) begin
            tok_v      = 1'b1;
            tok_kind   = KIND_CMD;
            phase_next = PH_GAPARG;
          end
        end
        PH_GAPARG: begin
          if (b == CH_COLON) begin
            start_next = pos + POS_W'(1);
            phase_next = PH_REST;
          end else if (b != CH_SPACE) begin
            start_next = pos;
            // argument at the limit takes the rest of the line
            if ({1'b0, arg_count} + (LIMIT_W+1)'(1) >= {1'b0, arg_limit}) begin
              phase_next = PH_REST;
            end else begin
              phase_next = PH_ARG;
            end
          end
        end
        PH_ARG: begin
          if (b == CH_SPACE) begin
            tok_v          = 1'b1;
            tok_kind       = KIND_ARG;
            tok_idx        = arg_count;
            arg_count_next = arg_count + LIMIT_W'(1);
            phase_next     = PH_GAPARG;
          end
        end
        default: begin
        end
      endcase
    end

    // line close on the final byte
    if (byte_item.end_of_line) begin
      case (phase_next)
        PH_START: fin_st = ST_NO_CMD;
        PH_TAGGAP: fin_st = (line_end <= POS_W'(1)) ? ST_EMPTY_TAGS : ST_NO_CMD;
        PH_TAG: begin
          fin_tok  = 1'b1;
          fin_kind = value_seen_next ? KIND_VALUE : KIND_KEY;
          fin_idx  = (tag_count_next != '0) ? tag_count_next - LIMIT_W'(1) : '0;
          fin_st   = ST_NO_CMD;
        end
        PH_GAPSRC, PH_GAPCMD: fin_st = ST_NO_CMD;
        PH_SRC: begin
          if (start_next >= line_end) begin
            fin_st = ST_EMPTY_SOURCE;
          end else begin
            fin_tok  = 1'b1;
            fin_kind = KIND_SOURCE;
            fin_idx  = '0;
            fin_st   = ST_NO_CMD;
          end
        end
        PH_CMD: begin
          fin_tok  = 1'b1;
          fin_kind = KIND_CMD;
          fin_idx  = '0;
          fin_st   = ST_OK;
        end
        PH_GAPARG: fin_st = ST_OK;
        PH_ARG, PH_REST: begin
          fin_tok  = 1'b1;
          fin_kind = KIND_ARG;
          fin_idx  = arg_count_next;
          fin_st   = ST_OK;
        end
        default: fin_st = err_next;
      endcase
      // the close token is only sent when the byte gave none
      if (fin_tok && !tok_v) begin
        tok_v    = 1'b1;
        tok_kind = fin_kind;
        tok_idx  = fin_idx;
        tok_s    = start_next;
        tok_e    = line_end;
      end
      phase_next      = PH_START;
      pos_next        = '0;
      start_next      = '0;
      tag_count_next  = '0;
      arg_count_next  = '0;
      value_seen_next = 1'b0;
      err_next        = ST_OK;
    end

    tok_len = (tok_e >= tok_s) ? tok_e - tok_s : '0;
  end

  // entry for the back end
  always_comb begin
    entry.tok_valid              = tok_v;
    entry.tok.token_kind         = tok_kind;
    entry.tok.token_index        = tok_idx[INDEX_W-1:0];
    entry.tok.token_start        = START_W'(tok_s);
    entry.tok.token_length       = LEN_W'(tok_len);
    entry.tok.parse_status       = ST_OK;
    entry.tok.last_of_line       = 1'b0;
    entry.sts_valid              = byte_item.end_of_line;
    entry.sts_code               = fin_st;
    entry_push                   = accept && (tok_v || byte_item.end_of_line);
  end

  // parser state and limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_START;
      pos        <= '0;
      start      <= '0;
      tag_count  <= '0;
      arg_count  <= '0;
      value_seen <= 1'b0;
      err        <= ST_OK;
      tag_limit  <= TAG_LIMIT_RESET;
      arg_limit  <= ARG_LIMIT_RESET;
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_TAG_LIMIT) begin
          tag_limit <= cfg_data;
        end else if (cfg_index == CFG_ARG_LIMIT) begin
          arg_limit <= cfg_data;
        end
      end
      if (accept) begin
        phase      <= phase_next;
        pos        <= pos_next;
        start      <= start_next;
        tag_count  <= tag_count_next;
        arg_count  <= arg_count_next;
        value_seen <= value_seen_next;
        err        <= err_next;
      end
    end
  end

endmodule

// File: rtl/ilt_queue.sv
// ----------------------------------------------------------------------------
// ilt_queue
// Short first-word-fall-through queue of parser entries between the front
// and the back end.
// ----------------------------------------------------------------------------
module ilt_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  ilt_pkg::entry_t wr_entry,
  output logic            full,
  input  logic            rd_en,
  output logic            avail,
  output ilt_pkg::entry_t head
);
  import ilt_pkg::*;

  entry_t              slots [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]   count;

  // status and head
  assign full  = (count == QCNT_W'(QDEPTH));
  assign avail = (count != '0);
  assign head  = slots[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + QCNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/ilt_back.sv
// ----------------------------------------------------------------------------
// ilt_back
// Output stage: holds one entry and hands out its token and status results
// one item per pop, loading the next entry as the last result leaves.
// ----------------------------------------------------------------------------
module ilt_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_avail,
  input  ilt_pkg::entry_t      q_head,
  output logic                 q_rd,
  output logic                 empty,
  input  logic                 pop,
  output ilt_pkg::token_item_t token_item
);
  import ilt_pkg::*;

  entry_t hold;
  logic   hold_valid;
  logic   tok_pend;
  logic   show_tok;
  logic   last_in_entry;
  logic   advance;

  // result selection
  always_comb begin
    show_tok      = hold.tok_valid && tok_pend;
    last_in_entry = !(show_tok && hold.sts_valid);
    advance       = pop && hold_valid;
    q_rd          = q_avail && (!hold_valid || (advance && last_in_entry));
    empty         = !hold_valid;
    if (show_tok) begin
      token_item = hold.tok;
    end else begin
      token_item.token_kind   = KIND_STATUS;
      token_item.token_index  = '0;
      token_item.token_start  = '0;
      token_item.token_length = '0;
      token_item.parse_status = hold.sts_code;
      token_item.last_of_line = 1'b1;
    end
  end

  // holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      tok_pend   <= 1'b0;
    end else if (q_rd) begin
      hold_valid <= 1'b1;
      tok_pend   <= q_head.tok_valid;
    end else if (advance) begin
      if (last_in_entry) begin
        hold_valid <= 1'b0;
      end else begin
        tok_pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      hold <= q_head;
    end
  end

endmodule

// File: rtl/irc_line_tokenizer_top.sv
// ----------------------------------------------------------------------------
// irc_line_tokenizer_top
// IRC line tokenizer: byte-per-cycle parser, while the queue is not full, feeding a result queue.
// ----------------------------------------------------------------------------
// Takes one byte of an IRC line per cycle, back to back while full is low, with
// end_of_line set on the final byte, and returns token descriptors (tag key and
// value, source, command, arguments) followed by one status item that closes
// each line. The front parser settles each byte combinationally; its results
// enter a four-entry queue and then the holding register of the output stage
// before they reach the result ports. A byte yields at most a token and a
// status, so a line end costs two pops on the result side; the queue absorbs
// that and any stall of the consumer, and full rises only when the queue is out
// of room. There is no clearing pass after reset. tag_limit (index 0) and
// arg_limit (index 1) are written through the cfg port, which is always ready
// and should be used only while the block is idle.
module irc_line_tokenizer_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  ilt_pkg::byte_item_t           byte_item,
  output logic                          empty,
  input  logic                          pop,
  output ilt_pkg::token_item_t          token_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ilt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ilt_pkg::LIMIT_W-1:0]   cfg_data
);
  import ilt_pkg::*;

  logic   accept;
  logic   entry_push;
  entry_t entry;
  logic   q_full;
  logic   q_rd;
  logic   q_avail;
  entry_t q_head;

  assign cfg_ready = 1'b1;
  assign full      = q_full;
  assign accept    = push && !q_full;

  // byte parser
  ilt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .byte_item  (byte_item),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .entry_push (entry_push),
    .entry      (entry)
  );

  // entry queue
  ilt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (entry_push),
    .wr_entry (entry),
    .full     (q_full),
    .rd_en    (q_rd),
    .avail    (q_avail),
    .head     (q_head)
  );

  // result output stage
  ilt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_avail    (q_avail),
    .q_head     (q_head),
    .q_rd       (q_rd),
    .empty      (empty),
    .pop        (pop),
    .token_item (token_item)
  );

`ifndef SYNTH
  // queue never written while full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(entry_push && q_full))
    else $error("entry written into a full queue");

  // nothing to pop right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result shown right after reset");

  // status items close a line, token items carry no status
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ((token_item.token_kind == KIND_STATUS) == token_item.last_of_line))
    else $error("status item and line close disagree");

  a_token_ok: assert property (@(posedge clk) disable iff (rst)
    (!empty && !token_item.last_of_line) |-> (token_item.parse_status == ST_OK))
    else $error("token item with nonzero status");
`endif

endmodule
